// File: hw/rtl/dpd_pkg.sv
// Shared types and constants for the detector proposal decoder.
// Used by dpd_div, dpd_datapath, dpd_ctrl and detector_proposal_decode_core.
// Depends on nothing.
package dpd_pkg;

   localparam int VALUE_W  = 32;
   localparam int THR_W    = 17;
   localparam int CC_W     = 11;
   localparam int NET_W    = 13;
   localparam int IMG_W    = 14;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;
   localparam int IDX_W    = 16;
   localparam int POS_OUT_W = 13;
   localparam int BOX_OUT_W = 14;
   localparam int LABEL_W  = 10;
   localparam int SCORE_W  = 31;
   localparam int DIVISOR_W = 14;
   localparam int PAD_W    = 26;
   localparam int PROD_W   = 27;

   localparam logic [CSR_IDX_W-1:0] CSR_CONF_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NET_WIDTH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NET_HEIGHT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_WIDTH      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_HEIGHT     = 3'd5;

   localparam logic [THR_W-1:0] THR_RESET = 17'd32768;
   localparam logic [CC_W-1:0]  CC_RESET  = 11'd80;
   localparam logic [NET_W-1:0] NET_W_RESET = 13'd640;
   localparam logic [NET_W-1:0] NET_H_RESET = 13'd640;
   localparam logic [IMG_W-1:0] IMG_W_RESET = 14'd1920;
   localparam logic [IMG_W-1:0] IMG_H_RESET = 14'd1080;

   localparam logic [NET_W-1:0] NET_MAX = 13'd4096;
   localparam logic [IMG_W-1:0] IMG_MAX = 14'd8192;

   // Edge order used by the box sequencer.
   localparam logic [1:0] EDGE_LEFT   = 2'd0;
   localparam logic [1:0] EDGE_RIGHT  = 2'd1;
   localparam logic [1:0] EDGE_TOP    = 2'd2;
   localparam logic [1:0] EDGE_BOTTOM = 2'd3;

   typedef struct packed {
      logic       accept;
      logic       load_score;
      logic       load_geom;
      logic       load_num;
      logic       div_start;
      logic       div_sel;
      logic       load_prod;
      logic       store_edge;
      logic       load_out;
      logic [1:0] edge_sel;
   } cmd_type;

   typedef struct packed {
      logic item_last;
      logic emit;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// File: hw/rtl/dpd_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Uses dpd_pkg for the divisor width.
module dpd_div #(
   parameter int DW = 31
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [DW-1:0]                    dividend,
   input  logic [dpd_pkg::DIVISOR_W-1:0]    divisor,
   output logic                             done,
   output logic                             busy,
   output logic [DW-1:0]                    quotient
);

   localparam int CW = $clog2(DW + 1);
   localparam int RW = dpd_pkg::DIVISOR_W;

   logic [DW-1:0] quo_ff, quo_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [RW:0]   rem_sh;
   logic          ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DW-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_in = ge ? RW'(rem_sh - {1'b0, dvs_ff}) : RW'(rem_sh);
      quo_in = {quo_ff[DW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/dpd_datapath.sv
// Datapath of the proposal decoder: configuration, stream registers, score
// product, box unscaling and the result register. Uses dpd_pkg and dpd_div.
module dpd_datapath #(
   parameter int MAX_CLASSES = 1024,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dpd_pkg::cmd_type                    cmd,
   output dpd_pkg::status_type                 status,
   input  logic signed [dpd_pkg::VALUE_W-1:0]  req_value,
   input  logic                                req_frame_start,
   input  logic                                csr_we,
   input  logic [dpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dpd_pkg::CSR_DAT_W-1:0]       csr_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [dpd_pkg::IDX_W-1:0]           rsp_proposal_index,
   output logic [dpd_pkg::POS_OUT_W-1:0]       rsp_left,
   output logic [dpd_pkg::POS_OUT_W-1:0]       rsp_top,
   output logic signed [dpd_pkg::BOX_OUT_W-1:0] rsp_box_width,
   output logic signed [dpd_pkg::BOX_OUT_W-1:0] rsp_box_height,
   output logic [dpd_pkg::LABEL_W-1:0]         rsp_class_label,
   output logic [dpd_pkg::SCORE_W-1:0]         rsp_score
);

   localparam int PW = $clog2(MAX_CLASSES + 5);
   // Bound on the magnitude of the first truncated quotient.
   localparam int FW = (33 - FRAC_BITS > 12) ? 33 - FRAC_BITS : 12;
   localparam int DW = FW + dpd_pkg::DIVISOR_W;
   localparam int NW = (FRAC_BITS + 27 > 48) ? FRAC_BITS + 27 : 48;
   localparam int VW = dpd_pkg::VALUE_W;
   localparam int OW = dpd_pkg::POS_OUT_W;

   function automatic logic [dpd_pkg::NET_W-1:0] sat_net(input logic [dpd_pkg::NET_W-1:0] v);
      logic [dpd_pkg::NET_W-1:0] r;
      r = v;
      if (v == '0) r = dpd_pkg::NET_W'(1);
      else if (v > dpd_pkg::NET_MAX) r = dpd_pkg::NET_MAX;
      return r;
   endfunction

   function automatic logic [dpd_pkg::IMG_W-1:0] sat_img(input logic [dpd_pkg::IMG_W-1:0] v);
      logic [dpd_pkg::IMG_W-1:0] r;
      r = v;
      if (v == '0) r = dpd_pkg::IMG_W'(1);
      else if (v > dpd_pkg::IMG_MAX) r = dpd_pkg::IMG_MAX;
      return r;
   endfunction

   // Configuration registers.
   logic [dpd_pkg::THR_W-1:0] thr_ff;
   logic [dpd_pkg::CC_W-1:0]  cc_ff;
   logic [dpd_pkg::NET_W-1:0] net_w_ff, net_h_ff;
   logic [dpd_pkg::IMG_W-1:0] img_w_ff, img_h_ff;

   // Stream state.
   logic [PW-1:0]                 pos_ff, pos_eff, last_pos;
   logic [dpd_pkg::IDX_W-1:0]     cnt_ff, cnt_eff, idx_ff;
   logic signed [VW-1:0]          box_ff [4];
   logic signed [VW-1:0]          obj_ff, best_ff;
   logic [dpd_pkg::LABEL_W-1:0]   bidx_ff;
   logic [31:0]                   nc;

   // Score and geometry.
   logic signed [63:0]            p_ff;
   logic [dpd_pkg::PROD_W-1:0]    hw_ff, wh_ff;
   logic [dpd_pkg::NET_W-1:0]     w_ff, h_ff;
   logic [dpd_pkg::IMG_W-1:0]     iw_ff, ih_ff;
   logic                          case_a_ff;
   logic [dpd_pkg::PAD_W-1:0]     pad_ff;

   // Edge arithmetic.
   logic                          axis_y, plus, padded;
   logic [dpd_pkg::DIVISOR_W-1:0] padden, mul, lim;
   logic [dpd_pkg::NET_W-1:0]     div2;
   logic signed [VW-1:0]          ctr, sz;
   logic signed [33:0]            ctr_ext, sz_ext, s;
   logic signed [NW-1:0]          num_ff, padterm;
   logic [NW-1:0]                 num_mag;
   logic [DW-1:0]                 dividend1, prod_ff, div_a, div_q, limm1;
   logic [dpd_pkg::DIVISOR_W-1:0] div_b;
   logic                          div_done, div_busy;
   logic [OW-1:0]                 edge_val;
   logic [OW-1:0]                 edge_ff [4];

   logic                          rsp_valid_ff;
   logic [dpd_pkg::IDX_W-1:0]     rsp_idx_ff;
   logic [OW-1:0]                 rsp_left_ff, rsp_top_ff;
   logic [dpd_pkg::BOX_OUT_W-1:0] rsp_bw_ff, rsp_bh_ff;
   logic [dpd_pkg::LABEL_W-1:0]   rsp_label_ff;
   logic [dpd_pkg::SCORE_W-1:0]   rsp_score_ff, score_sat;
   logic signed [VW-1:0]          thr32;
   logic signed [63:0]            thr64;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= dpd_pkg::THR_RESET;
         cc_ff    <= dpd_pkg::CC_RESET;
         net_w_ff <= dpd_pkg::NET_W_RESET;
         net_h_ff <= dpd_pkg::NET_H_RESET;
         img_w_ff <= dpd_pkg::IMG_W_RESET;
         img_h_ff <= dpd_pkg::IMG_H_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dpd_pkg::CSR_CONF_THRESHOLD: thr_ff   <= csr_data;
            dpd_pkg::CSR_CLASS_COUNT:    cc_ff    <= csr_data[dpd_pkg::CC_W-1:0];
            dpd_pkg::CSR_NET_WIDTH:      net_w_ff <= csr_data[dpd_pkg::NET_W-1:0];
            dpd_pkg::CSR_NET_HEIGHT:     net_h_ff <= csr_data[dpd_pkg::NET_W-1:0];
            dpd_pkg::CSR_IMG_WIDTH:      img_w_ff <= csr_data[dpd_pkg::IMG_W-1:0];
            dpd_pkg::CSR_IMG_HEIGHT:     img_h_ff <= csr_data[dpd_pkg::IMG_W-1:0];
            default: ;
         endcase
      end
   end

   // Element position within the proposal and the end-of-proposal test.
   always_comb begin
      if (cc_ff == '0) nc = 32'd1;
      else if (32'(cc_ff) > 32'(MAX_CLASSES)) nc = 32'(MAX_CLASSES);
      else nc = 32'(cc_ff);
      last_pos = PW'(nc + 32'd4);
      pos_eff  = req_frame_start ? '0 : pos_ff;
      cnt_eff  = req_frame_start ? '0 : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.accept) begin
         if (pos_eff >= last_pos) begin
            pos_ff <= '0;
            cnt_ff <= cnt_eff + dpd_pkg::IDX_W'(1);
         end else begin
            pos_ff <= pos_eff + PW'(1);
            cnt_ff <= cnt_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (pos_eff < PW'(4)) begin
            box_ff[pos_eff[1:0]] <= req_value;
         end else if (pos_eff == PW'(4)) begin
            obj_ff <= req_value;
         end else if (pos_eff == PW'(5) || req_value > best_ff) begin
            best_ff <= req_value;
            bidx_ff <= dpd_pkg::LABEL_W'(pos_eff - PW'(5));
         end
         if (pos_eff >= last_pos) idx_ff <= cnt_eff;
      end
   end

   // Score product and the letterbox geometry.
   always_ff @(posedge clock) begin
      if (cmd.load_score) begin
         p_ff  <= 64'(obj_ff) * 64'(best_ff);
         w_ff  <= sat_net(net_w_ff);
         h_ff  <= sat_net(net_h_ff);
         iw_ff <= sat_img(img_w_ff);
         ih_ff <= sat_img(img_h_ff);
         hw_ff <= dpd_pkg::PROD_W'(sat_net(net_h_ff)) * dpd_pkg::PROD_W'(sat_img(img_w_ff));
         wh_ff <= dpd_pkg::PROD_W'(sat_net(net_w_ff)) * dpd_pkg::PROD_W'(sat_img(img_h_ff));
      end
      if (cmd.load_geom) begin
         case_a_ff <= hw_ff > wh_ff;
         pad_ff    <= (hw_ff > wh_ff) ? dpd_pkg::PAD_W'(hw_ff - wh_ff)
                                      : dpd_pkg::PAD_W'(wh_ff - hw_ff);
      end
   end

   always_comb begin
      thr32 = $signed(VW'(thr_ff));
      thr64 = $signed(64'(thr_ff) << FRAC_BITS);
      if (p_ff[63:FRAC_BITS+31] != '0) score_sat = '1;
      else score_sat = p_ff[FRAC_BITS+30:FRAC_BITS];
   end

   // Per-edge operands: which axis, which sign of the half size, padding.
   always_comb begin
      axis_y  = cmd.edge_sel[1];
      plus    = cmd.edge_sel[0];
      padded  = axis_y ? case_a_ff : !case_a_ff;
      mul     = case_a_ff ? iw_ff : ih_ff;
      div2    = case_a_ff ? w_ff : h_ff;
      padden  = padded ? mul : dpd_pkg::DIVISOR_W'(1);
      lim     = axis_y ? ih_ff : iw_ff;
      ctr     = axis_y ? box_ff[1] : box_ff[0];
      sz      = axis_y ? box_ff[3] : box_ff[2];
      ctr_ext = 34'(ctr);
      sz_ext  = 34'(sz);
      s       = plus ? (ctr_ext <<< 1) + sz_ext : (ctr_ext <<< 1) - sz_ext;
      padterm = padded ? $signed(NW'(pad_ff) << FRAC_BITS) : '0;
      num_mag = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
      dividend1 = DW'(num_mag >> (FRAC_BITS + 1));
      div_a   = cmd.div_sel ? prod_ff : dividend1;
      div_b   = cmd.div_sel ? dpd_pkg::DIVISOR_W'(div2) : padden;
      limm1   = DW'(lim) - DW'(1);
      if (num_ff[NW-1]) edge_val = '0;
      else if (div_q > limm1) edge_val = OW'(limm1);
      else edge_val = OW'(div_q);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_num) num_ff <= $signed(NW'(s) * NW'({1'b0, padden})) - padterm;
      if (cmd.load_prod) prod_ff <= DW'(div_q[FW-1:0]) * DW'(mul);
      if (cmd.store_edge) edge_ff[cmd.edge_sel] <= edge_val;
   end

   dpd_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_idx_ff   <= idx_ff;
         rsp_left_ff  <= edge_ff[dpd_pkg::EDGE_LEFT];
         rsp_top_ff   <= edge_ff[dpd_pkg::EDGE_TOP];
         rsp_bw_ff    <= dpd_pkg::BOX_OUT_W'({1'b0, edge_ff[dpd_pkg::EDGE_RIGHT]}
                         - {1'b0, edge_ff[dpd_pkg::EDGE_LEFT]});
         rsp_bh_ff    <= dpd_pkg::BOX_OUT_W'({1'b0, edge_ff[dpd_pkg::EDGE_BOTTOM]}
                         - {1'b0, edge_ff[dpd_pkg::EDGE_TOP]});
         rsp_label_ff <= bidx_ff;
         rsp_score_ff <= score_sat;
      end
   end

   always_comb begin
      status.item_last = pos_eff >= last_pos;
      status.emit      = (obj_ff > thr32) && (p_ff > thr64);
      status.div_done  = div_done;
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_proposal_index = rsp_idx_ff;
   assign rsp_left           = rsp_left_ff;
   assign rsp_top            = rsp_top_ff;
   assign rsp_box_width      = $signed(rsp_bw_ff);
   assign rsp_box_height     = $signed(rsp_bh_ff);
   assign rsp_class_label    = rsp_label_ff;
   assign rsp_score          = rsp_score_ff;

   a_div_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");

   a_out_free_at_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(MAX_CLASSES + 4))
      else $error("element position out of range");

endmodule

// File: hw/rtl/dpd_ctrl.sv
// Controller of the proposal decoder: sequences score, decision and the four
// box edges through the shared divider. Uses dpd_pkg.
module dpd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dpd_pkg::status_type status,
   output dpd_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_ACCEPT, ST_SCORE, ST_DECIDE, ST_NUM, ST_D1, ST_W1,
      ST_PROD, ST_D2, ST_W2, ST_STORE, ST_FIN
   } state_type;

   state_type  state_ff;
   logic [1:0] edge_ff;
   logic       accept;

   assign accept    = req_valid && (state_ff == ST_ACCEPT);
   assign req_stall = state_ff != ST_ACCEPT;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         edge_ff  <= dpd_pkg::EDGE_LEFT;
      end else begin
         case (state_ff)
            ST_ACCEPT: if (accept && status.item_last) state_ff <= ST_SCORE;
            ST_SCORE:  state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               edge_ff  <= dpd_pkg::EDGE_LEFT;
               state_ff <= status.emit ? ST_NUM : ST_ACCEPT;
            end
            ST_NUM:    state_ff <= ST_D1;
            ST_D1:     state_ff <= ST_W1;
            ST_W1:     if (status.div_done) state_ff <= ST_PROD;
            ST_PROD:   state_ff <= ST_D2;
            ST_D2:     state_ff <= ST_W2;
            ST_W2:     if (status.div_done) state_ff <= ST_STORE;
            ST_STORE: begin
               edge_ff  <= edge_ff + 2'd1;
               state_ff <= (edge_ff == dpd_pkg::EDGE_BOTTOM) ? ST_FIN : ST_NUM;
            end
            ST_FIN:    if (status.out_free) state_ff <= ST_ACCEPT;
            default:   state_ff <= ST_ACCEPT;
         endcase
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.accept     = accept;
      cmd.edge_sel   = edge_ff;
      cmd.load_score = state_ff == ST_SCORE;
      cmd.load_geom  = state_ff == ST_DECIDE;
      cmd.load_num   = state_ff == ST_NUM;
      cmd.div_start  = (state_ff == ST_D1) || (state_ff == ST_D2);
      cmd.div_sel    = (state_ff == ST_D2) || (state_ff == ST_W2) || (state_ff == ST_PROD);
      cmd.load_prod  = state_ff == ST_PROD;
      cmd.store_edge = state_ff == ST_STORE;
      cmd.load_out   = (state_ff == ST_FIN) && status.out_free;
   end

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_W1 || state_ff == ST_W2))
      else $error("divider finished outside a wait state");

   a_emit_starts_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && status.emit) |=>
      (state_ff == ST_NUM && edge_ff == dpd_pkg::EDGE_LEFT))
      else $error("box sequence did not start at the left edge");

   a_edge_moves_on_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_STORE && state_ff != ST_DECIDE) |=> $stable(edge_ff))
      else $error("edge counter changed outside a store");

endmodule

// File: hw/rtl/detector_proposal_decode_core.sv
// The divider width is DW = max(47-FRAC_BITS, 26), which is 31 at Q16.16.
// Throughput: one element per cycle while the input is not stalled; after each
// proposal's last score the input stalls through ST_SCORE and ST_DECIDE, and
// also through the full box sequence when the proposal emits.
// The box sequence uses the one-bit-per-cycle divider twice per edge.
// Reset (synchronous, active high) loads register defaults and clears counters.
//
// Depends on dpd_pkg, dpd_ctrl, dpd_datapath and dpd_div.
module detector_proposal_decode_core #(
   parameter int MAX_CLASSES = 1024,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel: one tensor element per transaction.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [dpd_pkg::VALUE_W-1:0]   req_value,
   input  logic                                 req_frame_start,
   // Result channel: one detection per transaction.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dpd_pkg::IDX_W-1:0]            rsp_proposal_index,
   output logic [dpd_pkg::POS_OUT_W-1:0]        rsp_left,
   output logic [dpd_pkg::POS_OUT_W-1:0]        rsp_top,
   output logic signed [dpd_pkg::BOX_OUT_W-1:0] rsp_box_width,
   output logic signed [dpd_pkg::BOX_OUT_W-1:0] rsp_box_height,
   output logic [dpd_pkg::LABEL_W-1:0]          rsp_class_label,
   output logic [dpd_pkg::SCORE_W-1:0]          rsp_score,
   // Register write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dpd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dpd_pkg::CSR_DAT_W-1:0]        csr_data
);

   // Registers are always writable; writes are expected only while idle.
   assign csr_ready = 1'b1;

   dpd_pkg::cmd_type    cmd;
   dpd_pkg::status_type status;

   // The controller owns the input handshake and walks each emitting
   // proposal through score, decision and four box edges.
   dpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the stream registers, the arithmetic and the result
   // register, which lets a finished detection wait while new elements flow.
   dpd_datapath #(
      .MAX_CLASSES (MAX_CLASSES),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_value          (req_value),
      .req_frame_start    (req_frame_start),
      .csr_we             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_proposal_index (rsp_proposal_index),
      .rsp_left           (rsp_left),
      .rsp_top            (rsp_top),
      .rsp_box_width      (rsp_box_width),
      .rsp_box_height     (rsp_box_height),
      .rsp_class_label    (rsp_class_label),
      .rsp_score          (rsp_score)
   );

endmodule
